FILE: hw/rtl/world_to_screen_projection_defines.svh
// Assertion macros shared by the projection RTL.
// Needs clk and rst in the scope where a macro is used.
`ifndef WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH

// same-cycle implication, off during reset
`define WTSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, also checked during reset
`define WTSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/wtsp_pkg.sv
// Types and constants of the world-to-screen projection block.
// No dependencies; used by wtsp_div_pipe and world_to_screen_projection.
package wtsp_pkg;

  localparam int CRD_W     = 32;           // Q24.8 point and pixel fields
  localparam int DIM_W     = 14;           // viewport size
  localparam int ADDR_W    = 6;            // 8 registers at 8-byte spacing
  localparam int DATA_W    = 64;
  localparam int ACC_W     = 58;           // dot product sum, Q.24
  localparam int NUM_W     = ACC_W;        // divider numerator/denominator
  localparam int FRAC_BITS = 24;           // ndc fraction bits
  localparam int CAP_SHIFT = 25;           // ndc integer part cap is 2^25
  localparam int DIV_STEPS = CAP_SHIFT + FRAC_BITS;
  localparam int DIV_LAT   = DIV_STEPS + 1;
  localparam int Q_W       = DIV_STEPS + 1; // quotient incl. cap value
  localparam int NDC_W     = Q_W + 1;
  localparam int MP_W      = NDC_W + DIM_W + 1;
  localparam int SUM_W     = 52;
  localparam int SCR_SHIFT = 17;
  localparam int PIPE_DEPTH = DIV_LAT + 5;

  localparam logic signed [ACC_W-1:0] W_MIN    = ACC_W'(167773); // ceil(0.01 * 2^24)
  localparam logic [7:0]              HALF_PIX = 8'd128;
  localparam logic [DIM_W-1:0]        WIDTH_RST  = DIM_W'(1920);
  localparam logic [DIM_W-1:0]        HEIGHT_RST = DIM_W'(1080);

  typedef enum logic [2:0] {
    CFG_ROW_X_A = 3'd0,
    CFG_ROW_X_B = 3'd1,
    CFG_ROW_Y_A = 3'd2,
    CFG_ROW_Y_B = 3'd3,
    CFG_ROW_W_A = 3'd4,
    CFG_ROW_W_B = 3'd5,
    CFG_WIDTH   = 3'd6,
    CFG_HEIGHT  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] point_x;
    logic signed [CRD_W-1:0] point_y;
    logic signed [CRD_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic                    visible;
    logic signed [CRD_W-1:0] screen_x;
    logic signed [CRD_W-1:0] screen_y;
  } result_t;

  typedef struct packed {
    logic visible;
    logic neg_x;
    logic neg_y;
  } flags_t;

endpackage

FILE: hw/rtl/wtsp_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, ndc cap detect.
// Depends on wtsp_pkg.
module wtsp_div_pipe (
  input  logic                          clk,
  input  logic                          en,
  input  logic [wtsp_pkg::NUM_W-1:0]    num,
  input  logic [wtsp_pkg::NUM_W-1:0]    den,
  output logic [wtsp_pkg::Q_W-1:0]      quot
);

  logic [wtsp_pkg::NUM_W-1:0]     rem   [wtsp_pkg::DIV_STEPS+1];
  logic [wtsp_pkg::NUM_W-1:0]     den_s [wtsp_pkg::DIV_STEPS+1];
  logic [wtsp_pkg::CAP_SHIFT-1:0] nlo   [wtsp_pkg::DIV_STEPS+1];
  logic [wtsp_pkg::DIV_STEPS-1:0] q     [wtsp_pkg::DIV_STEPS+1];
  logic                           cap   [wtsp_pkg::DIV_STEPS+1];

  // setup: partial remainder starts with the bits above the cap position
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= wtsp_pkg::NUM_W'(num[wtsp_pkg::NUM_W-1:wtsp_pkg::CAP_SHIFT]);
      nlo[0]   <= num[wtsp_pkg::CAP_SHIFT-1:0];
      den_s[0] <= den;
      q[0]     <= '0;
      cap[0]   <= (wtsp_pkg::NUM_W'(num[wtsp_pkg::NUM_W-1:wtsp_pkg::CAP_SHIFT]) >= den);
    end
  end

  for (genvar k = 0; k < wtsp_pkg::DIV_STEPS; k++) begin : g_step
    localparam int QB = wtsp_pkg::DIV_STEPS - 1 - k;
    logic                         dbit;
    logic [wtsp_pkg::NUM_W:0]     t;
    logic                         ge;

    if (QB >= wtsp_pkg::FRAC_BITS) begin : g_num
      assign dbit = nlo[k][QB - wtsp_pkg::FRAC_BITS];
    end else begin : g_zero
      assign dbit = 1'b0;
    end

    assign t  = {rem[k], dbit};
    assign ge = (t >= {1'b0, den_s[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]   <= ge ? wtsp_pkg::NUM_W'(t - {1'b0, den_s[k]}) : wtsp_pkg::NUM_W'(t);
        nlo[k+1]   <= nlo[k];
        den_s[k+1] <= den_s[k];
        q[k+1]     <= {q[k][wtsp_pkg::DIV_STEPS-2:0], ge};
        cap[k+1]   <= cap[k];
      end
    end
  end

  assign quot = cap[wtsp_pkg::DIV_STEPS]
              ? (wtsp_pkg::Q_W'(1) << wtsp_pkg::DIV_STEPS)
              : {1'b0, q[wtsp_pkg::DIV_STEPS]};

endmodule

FILE: hw/rtl/world_to_screen_projection.sv
// Top level of the world-to-screen projection block.
// Depends on wtsp_pkg, wtsp_div_pipe and world_to_screen_projection_defines.svh.
//
// Usage:
//   Request channel (req_valid/req_stall/req) carries one world point, Q24.8.
//   Result channel (res_valid/res_stall/res) returns visible, screen_x,
//   screen_y (Q24.8, saturated; zero when the point is behind the camera).
//   The APB port holds the three matrix rows (64-bit registers at 8*i) and
//   the viewport size; write it only while no request is in flight.
// Timing:
//   One request is taken per cycle while req_stall is low. The pipeline depth
//   comes from the two 50-stage quotient pipes (a setup stage, then one quotient
//   bit per stage) plus multiply, sum, magnitude, sign, scale and output stages.
// Stall:
//   The pipeline runs while the skid register is empty. A result that finds
//   the output register held goes to the skid register, and req_stall rises
//   until the output drains; nothing is dropped or repeated.
// Reset:
//   rst (synchronous) empties the pipeline, output and skid; matrix rows go
//   to zero, viewport to 1920 x 1080.
`include "world_to_screen_projection_defines.svh"

module world_to_screen_projection (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  wtsp_pkg::point_t              req,
  // result channel
  output logic                          res_valid,
  input  logic                          res_stall,
  output wtsp_pkg::result_t             res,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wtsp_pkg::ADDR_W-1:0]   paddr,
  input  logic [wtsp_pkg::DATA_W-1:0]   pwdata,
  output logic [wtsp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  // ---------------- configuration registers ----------------
  logic [wtsp_pkg::DATA_W-1:0] row_x_a, row_x_b, row_y_a, row_y_b, row_w_a, row_w_b;
  logic [wtsp_pkg::DIM_W-1:0]  scr_w, scr_h;
  wtsp_pkg::cfg_idx_t          cfg_idx;
  logic                        cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = wtsp_pkg::cfg_idx_t'(paddr[wtsp_pkg::ADDR_W-1:3]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x_a <= '0;
      row_x_b <= '0;
      row_y_a <= '0;
      row_y_b <= '0;
      row_w_a <= '0;
      row_w_b <= '0;
      scr_w   <= wtsp_pkg::WIDTH_RST;
      scr_h   <= wtsp_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        wtsp_pkg::CFG_ROW_X_A: row_x_a <= pwdata;
        wtsp_pkg::CFG_ROW_X_B: row_x_b <= pwdata;
        wtsp_pkg::CFG_ROW_Y_A: row_y_a <= pwdata;
        wtsp_pkg::CFG_ROW_Y_B: row_y_b <= pwdata;
        wtsp_pkg::CFG_ROW_W_A: row_w_a <= pwdata;
        wtsp_pkg::CFG_ROW_W_B: row_w_b <= pwdata;
        wtsp_pkg::CFG_WIDTH:   scr_w   <= pwdata[wtsp_pkg::DIM_W-1:0];
        wtsp_pkg::CFG_HEIGHT:  scr_h   <= pwdata[wtsp_pkg::DIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      wtsp_pkg::CFG_ROW_X_A: prdata = row_x_a;
      wtsp_pkg::CFG_ROW_X_B: prdata = row_x_b;
      wtsp_pkg::CFG_ROW_Y_A: prdata = row_y_a;
      wtsp_pkg::CFG_ROW_Y_B: prdata = row_y_b;
      wtsp_pkg::CFG_ROW_W_A: prdata = row_w_a;
      wtsp_pkg::CFG_ROW_W_B: prdata = row_w_b;
      wtsp_pkg::CFG_WIDTH:   prdata = wtsp_pkg::DATA_W'(scr_w);
      wtsp_pkg::CFG_HEIGHT:  prdata = wtsp_pkg::DATA_W'(scr_h);
    endcase
  end

  // ---------------- pipeline control ----------------
  // Every stage moves together while the skid register is empty.
  logic                            adv;
  logic [wtsp_pkg::PIPE_DEPTH-1:0] pipe_vld;
  logic                            skid_valid;
  wtsp_pkg::result_t               skid;

  assign adv       = !skid_valid;
  assign req_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld <= '0;
    end else if (adv) begin
      pipe_vld <= {pipe_vld[wtsp_pkg::PIPE_DEPTH-2:0], req_valid};
    end
  end

  // ---------------- stage 1: the nine products ----------------
  // rows: 0 = x, 1 = y, 2 = w; columns: point x, y, z
  logic signed [31:0] coef  [3][3];
  logic signed [31:0] trans [3];
  logic signed [63:0] prod  [3][3];

  assign coef[0][0] = row_x_a[31:0];
  assign coef[0][1] = row_x_a[63:32];
  assign coef[0][2] = row_x_b[31:0];
  assign trans[0]   = row_x_b[63:32];
  assign coef[1][0] = row_y_a[31:0];
  assign coef[1][1] = row_y_a[63:32];
  assign coef[1][2] = row_y_b[31:0];
  assign trans[1]   = row_y_b[63:32];
  assign coef[2][0] = row_w_a[31:0];
  assign coef[2][1] = row_w_a[63:32];
  assign coef[2][2] = row_w_b[31:0];
  assign trans[2]   = row_w_b[63:32];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        prod[r][0] <= coef[r][0] * req.point_x;
        prod[r][1] <= coef[r][1] * req.point_y;
        prod[r][2] <= coef[r][2] * req.point_z;
      end
    end
  end

  // ---------------- stage 2: row sums in Q.24 ----------------
  function automatic logic signed [wtsp_pkg::ACC_W-1:0] row_sum(
    input logic signed [63:0] p0,
    input logic signed [63:0] p1,
    input logic signed [63:0] p2,
    input logic signed [31:0] t
  );
    logic signed [63:0] s;
    s = (p0 >>> 8) + (p1 >>> 8) + (p2 >>> 8) + (64'(t) <<< 16);
    return s[wtsp_pkg::ACC_W-1:0];
  endfunction

  logic signed [wtsp_pkg::ACC_W-1:0] acc_x, acc_y, acc_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_x <= row_sum(prod[0][0], prod[0][1], prod[0][2], trans[0]);
      acc_y <= row_sum(prod[1][0], prod[1][1], prod[1][2], trans[1]);
      acc_w <= row_sum(prod[2][0], prod[2][1], prod[2][2], trans[2]);
    end
  end

  // ---------------- stage 3: visibility, magnitudes ----------------
  logic [wtsp_pkg::NUM_W-1:0] mag_x, mag_y, den;
  wtsp_pkg::flags_t           flg3;

  always_ff @(posedge clk) begin
    if (adv) begin
      flg3.visible <= (acc_w >= wtsp_pkg::W_MIN);
      flg3.neg_x   <= acc_x[wtsp_pkg::ACC_W-1];
      flg3.neg_y   <= acc_y[wtsp_pkg::ACC_W-1];
      mag_x <= acc_x[wtsp_pkg::ACC_W-1] ? wtsp_pkg::NUM_W'(-acc_x) : wtsp_pkg::NUM_W'(acc_x);
      mag_y <= acc_y[wtsp_pkg::ACC_W-1] ? wtsp_pkg::NUM_W'(-acc_y) : wtsp_pkg::NUM_W'(acc_y);
      den   <= wtsp_pkg::NUM_W'(acc_w);
    end
  end

  // ---------------- quotient pipes: ndc magnitude in Q.24 ----------------
  logic [wtsp_pkg::Q_W-1:0] quot_x, quot_y;
  wtsp_pkg::flags_t         flg_line [wtsp_pkg::DIV_LAT];

  wtsp_div_pipe u_div_x (
    .clk  (clk),
    .en   (adv),
    .num  (mag_x),
    .den  (den),
    .quot (quot_x)
  );

  wtsp_div_pipe u_div_y (
    .clk  (clk),
    .en   (adv),
    .num  (mag_y),
    .den  (den),
    .quot (quot_y)
  );

  // flags ride alongside the quotient pipes
  always_ff @(posedge clk) begin
    if (adv) begin
      flg_line[0] <= flg3;
      for (int i = 1; i < wtsp_pkg::DIV_LAT; i++) begin
        flg_line[i] <= flg_line[i-1];
      end
    end
  end

  // ---------------- stage 4: signed ndc ----------------
  logic signed [wtsp_pkg::NDC_W-1:0] ndc_x, ndc_y;
  logic                              vis4;

  always_ff @(posedge clk) begin
    if (adv) begin
      vis4  <= flg_line[wtsp_pkg::DIV_LAT-1].visible;
      ndc_x <= flg_line[wtsp_pkg::DIV_LAT-1].neg_x ? -$signed({1'b0, quot_x})
                                                   :  $signed({1'b0, quot_x});
      ndc_y <= flg_line[wtsp_pkg::DIV_LAT-1].neg_y ? -$signed({1'b0, quot_y})
                                                   :  $signed({1'b0, quot_y});
    end
  end

  // ---------------- stage 5: scale by viewport ----------------
  logic signed [wtsp_pkg::MP_W-1:0] scl_x, scl_y;
  logic                             vis5;

  always_ff @(posedge clk) begin
    if (adv) begin
      vis5  <= vis4;
      scl_x <= ndc_x * $signed({1'b0, scr_w});
      scl_y <= ndc_y * $signed({1'b0, scr_h});
    end
  end

  // ---------------- stage 6: offset, saturate ----------------
  function automatic logic signed [wtsp_pkg::CRD_W-1:0] sat32(
    input logic signed [wtsp_pkg::SUM_W-1:0] v
  );
    logic signed [wtsp_pkg::SUM_W-1:0] hi, lo;
    hi = wtsp_pkg::SUM_W'(2147483647);
    lo = -wtsp_pkg::SUM_W'(64'sd2147483648);
    priority if (v > hi) return hi[wtsp_pkg::CRD_W-1:0];
    else if (v < lo)     return lo[wtsp_pkg::CRD_W-1:0];
    else                 return v[wtsp_pkg::CRD_W-1:0];
  endfunction

  logic signed [wtsp_pkg::MP_W-1:0]  shf_x, shf_y;
  logic signed [wtsp_pkg::SUM_W-1:0] off_x, off_y, sum_x, sum_y;
  wtsp_pkg::result_t                 fin;

  always_comb begin
    shf_x = scl_x >>> wtsp_pkg::SCR_SHIFT;
    shf_y = scl_y >>> wtsp_pkg::SCR_SHIFT;
    // floor(W/2) in pixels plus half a pixel
    off_x = $signed(wtsp_pkg::SUM_W'({scr_w[wtsp_pkg::DIM_W-1:1], wtsp_pkg::HALF_PIX}));
    off_y = $signed(wtsp_pkg::SUM_W'({scr_h[wtsp_pkg::DIM_W-1:1], 8'd0}))
          - $signed(wtsp_pkg::SUM_W'(wtsp_pkg::HALF_PIX));
    sum_x = off_x + shf_x[wtsp_pkg::SUM_W-1:0];
    sum_y = off_y - shf_y[wtsp_pkg::SUM_W-1:0];   // y axis flipped
    fin.visible  = vis5;
    fin.screen_x = vis5 ? sat32(sum_x) : '0;
    fin.screen_y = vis5 ? sat32(sum_y) : '0;
  end

  // ---------------- output register and skid ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!res_stall) begin
        res        <= skid;
        skid_valid <= 1'b0;
      end
    end else if (pipe_vld[wtsp_pkg::PIPE_DEPTH-1]) begin
      if (!res_valid || !res_stall) begin
        res       <= fin;
        res_valid <= 1'b1;
      end else begin
        skid       <= fin;
        skid_valid <= 1'b1;
      end
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // ---------------- assertions ----------------
  `WTSP_ASSERT_IMP(a_skid_implies_out, skid_valid, res_valid, "skid holds data with output empty")
  `WTSP_ASSERT_IMP(a_skid_fill_cause, $rose(skid_valid), $past(res_valid && res_stall), "skid filled without a held output")
  `WTSP_ASSERT_IMP(a_hidden_zero, res_valid && !res.visible, res.screen_x == 0 && res.screen_y == 0, "hidden point with nonzero screen position")
  `WTSP_ASSERT_NEXT(a_reset_empty, rst, !res_valid && !skid_valid, "result pending after reset")

endmodule
